FILE: sv/bapd_pkg.sv
package bapd_pkg;

   // Width of a raw decimal sum of eight digits (at most 99999999).
   localparam int unsigned AccWidth   = 27;
   localparam int unsigned AngleWidth = 28;

   localparam logic [7:0] MARK_FIRST   = 8'd11;
   localparam logic [7:0] MARK_SECOND  = 8'd10;
   localparam logic [7:0] TRAILER_MIN  = 8'd9;
   localparam logic [7:0] TRAILER_END  = 8'd10;

   localparam logic [3:0] POS_TRAILER_FIRST  = 4'd8;
   localparam logic [3:0] POS_TRAILER_SECOND = 4'd9;

   localparam logic [AccWidth-1:0]   ANGLE_MAX_POSITIVE = 27'd9999999;
   localparam logic [AngleWidth-1:0] ANGLE_BIAS         = 28'd100000000;

   // Weight of each packed digit pair within one angle, least significant first.
   localparam logic [AccWidth-1:0] DIGIT_WEIGHT [4] =
      '{27'd1, 27'd100, 27'd10000, 27'd1000000};

   typedef enum logic [1:0] {
      STATUS_GOOD    = 2'd0,
      STATUS_DIGIT   = 2'd1,
      STATUS_TRAILER = 2'd2
   } status_type;

   // Control from the framing logic to the digit accumulator.
   typedef struct packed {
      logic       clear;
      logic       add;
      logic       lane;
      logic [1:0] weight_sel;
   } accum_ctrl_type;

   // Binary value of one packed BCD byte: high nibble times ten plus low nibble.
   function automatic logic [7:0] pair_value(input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'b0000, b[7:4]};
      lo = {4'b0000, b[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

   function automatic logic digit_bad(input logic [7:0] b);
      return (b[3:0] > 4'd9) || (b[7:4] > 4'd9);
   endfunction

   // Sums above the positive limit wrap into the negative range.
   function automatic logic signed [AngleWidth-1:0] fold_angle(
      input logic [AccWidth-1:0] raw
   );
      logic [AngleWidth-1:0] wide;
      wide = {1'b0, raw};
      if (raw > ANGLE_MAX_POSITIVE) begin
         return signed'(wide - ANGLE_BIAS);
      end
      return signed'(wide);
   endfunction

endpackage

FILE: sv/bapd_accum.sv
module bapd_accum (
   input  logic                                clock,
   input  bapd_pkg::accum_ctrl_type            ctrl,
   input  logic [7:0]                          rx_byte,
   output logic [bapd_pkg::AccWidth-1:0]       acc_first,
   output logic [bapd_pkg::AccWidth-1:0]       acc_second
);

   logic [bapd_pkg::AccWidth-1:0] acc_first_ff;
   logic [bapd_pkg::AccWidth-1:0] acc_first_in;
   logic [bapd_pkg::AccWidth-1:0] acc_second_ff;
   logic [bapd_pkg::AccWidth-1:0] acc_second_in;
   logic [bapd_pkg::AccWidth-1:0] pair_wide;
   logic [bapd_pkg::AccWidth-1:0] term;

   // Each digit pair is weighted as it arrives, so the angle is complete
   // as soon as its last byte has been taken.
   assign pair_wide = bapd_pkg::AccWidth'(bapd_pkg::pair_value(rx_byte));
   assign term      = pair_wide * bapd_pkg::DIGIT_WEIGHT[ctrl.weight_sel];

   always_comb begin
      acc_first_in  = acc_first_ff;
      acc_second_in = acc_second_ff;
      if (ctrl.clear) begin
         acc_first_in  = '0;
         acc_second_in = '0;
      end else if (ctrl.add) begin
         if (ctrl.lane) begin
            acc_second_in = acc_second_ff + term;
         end else begin
            acc_first_in = acc_first_ff + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_first_ff  <= acc_first_in;
      acc_second_ff <= acc_second_in;
   end

   assign acc_first  = acc_first_ff;
   assign acc_second = acc_second_ff;

endmodule

FILE: sv/bcd_angle_packet_deframer_core.sv
// Channel   | Direction | Beat contents
// ----------+-----------+-----------------------------------------------------------
// req_      | in        | one received byte from the sensor link
// rsp_      | out       | one decoded packet: two signed angles, status in tuser
//
// The block takes one beat per cycle, except while req_tready is held low as described below.
// A result appears on rsp_ in the cycle after the second trailer byte is taken.
// The accumulation of each digit pair (one constant-weight multiply and add) sets
// the critical path; the wrap of the angle range is done on the trailer byte.
// Reset is synchronous and active high; it restarts the marker search.
// req_tready falls only when a trailer byte would finish a packet while the
// previous result is still held on rsp_ and not being taken.
module bcd_angle_packet_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [27:0] angle_first, [55:28] angle_second
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   // Framing state.
   logic       hunting_ff;
   logic       hunting_in;
   logic [7:0] prev_ff;
   logic [7:0] prev_in;
   logic [3:0] pos_ff;
   logic [3:0] pos_in;
   logic       fault_ff;
   logic       fault_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [55:0]           rsp_data_ff;
   logic [55:0]           rsp_data_in;
   bapd_pkg::status_type  rsp_status_ff;
   bapd_pkg::status_type  rsp_status_in;

   logic                          req_fire;
   logic                          at_packet_end;
   logic                          marker_hit;
   logic                          trailer_ok;
   logic                          emit;
   bapd_pkg::status_type          status_new;
   bapd_pkg::accum_ctrl_type      accum_ctrl;
   logic [bapd_pkg::AccWidth-1:0] acc_first;
   logic [bapd_pkg::AccWidth-1:0] acc_second;

   bapd_accum u_accum (
      .clock      (clock),
      .ctrl       (accum_ctrl),
      .rx_byte    (req_tdata),
      .acc_first  (acc_first),
      .acc_second (acc_second)
   );

   // The byte about to arrive is the second trailer byte and will produce a result.
   assign at_packet_end = !hunting_ff && (pos_ff >= bapd_pkg::POS_TRAILER_SECOND);

   assign req_tready = !(at_packet_end && rsp_valid_ff && !rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign emit       = req_fire && at_packet_end;

   assign marker_hit = (prev_ff == bapd_pkg::MARK_FIRST) && (req_tdata == bapd_pkg::MARK_SECOND);
   assign trailer_ok = (prev_ff > bapd_pkg::TRAILER_MIN) && (req_tdata == bapd_pkg::TRAILER_END);

   // A digit fault outranks a bad trailer.
   always_comb begin
      if (fault_ff) begin
         status_new = bapd_pkg::STATUS_DIGIT;
      end else if (!trailer_ok) begin
         status_new = bapd_pkg::STATUS_TRAILER;
      end else begin
         status_new = bapd_pkg::STATUS_GOOD;
      end
   end

   // Next framing state and accumulator control for an accepted byte.
   always_comb begin
      hunting_in = hunting_ff;
      prev_in    = prev_ff;
      pos_in     = pos_ff;
      fault_in   = fault_ff;
      accum_ctrl = '{clear: 1'b0, add: 1'b0, lane: pos_ff[2], weight_sel: pos_ff[1:0]};
      if (req_fire) begin
         prev_in = req_tdata;
         if (hunting_ff) begin
            if (marker_hit) begin
               hunting_in       = 1'b0;
               pos_in           = '0;
               fault_in         = 1'b0;
               accum_ctrl.clear = 1'b1;
            end
         end else if (!pos_ff[3]) begin
            // Data bytes zero to seven: bytes four and up feed the second angle.
            fault_in       = fault_ff || bapd_pkg::digit_bad(req_tdata);
            pos_in         = pos_ff + 4'd1;
            accum_ctrl.add = 1'b1;
         end else if (pos_ff == bapd_pkg::POS_TRAILER_FIRST) begin
            pos_in = bapd_pkg::POS_TRAILER_SECOND;
         end else begin
            // A good trailer doubles as the next marker, so collection restarts.
            pos_in           = '0;
            fault_in         = 1'b0;
            accum_ctrl.clear = 1'b1;
            hunting_in       = (status_new != bapd_pkg::STATUS_GOOD);
         end
      end
   end

   // Result register: loads on a finished packet, holds while the sink stalls.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_new;
         if (status_new == bapd_pkg::STATUS_GOOD) begin
            rsp_data_in = {bapd_pkg::fold_angle(acc_second), bapd_pkg::fold_angle(acc_first)};
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff   <= 1'b1;
         prev_ff      <= '0;
         pos_ff       <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hunting_ff   <= hunting_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // The input is held back only by a stalled result that a new packet would overwrite.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_valid_ff && !rsp_tready && at_packet_end))
      else $error("input stalled without a pending result");

   // A faulted packet sends the block back to the marker search.
   assert property (@(posedge clock) disable iff (reset)
      (emit && (status_new != bapd_pkg::STATUS_GOOD)) |=> hunting_ff)
      else $error("fault did not restart marker search");

   // Faulted results carry no angles.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != bapd_pkg::STATUS_GOOD)) |-> (rsp_data_ff == '0))
      else $error("faulted result carries angle data");

   // The packet position stays within the data and trailer bytes.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (pos_ff <= bapd_pkg::POS_TRAILER_SECOND))
      else $error("packet position out of range");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   // Generous bound on the whole run.
   localparam int CYCLE_LIMIT  = 200000;
   // The block answers in the cycle after the closing trailer byte is taken, so a short drain suffices.
   localparam int DRAIN_CYCLES = 20;
   // Length of the deliberate hold-off on the result side.
   localparam int HOLD_CYCLES  = 400;

   // One decoded packet as it should appear on the result channel.
   typedef struct packed {
      logic [27:0]          first;
      logic [27:0]          second;
      bapd_pkg::status_type status;
   } angle_packet_type;

   // Tracks the framing of the byte stream and holds the packets still to come out.
   class angle_frame_tracker;
      logic               hunting;
      logic [7:0]         last_byte;
      logic [3:0]         position;
      logic [63:0]        digits;
      logic               digit_fault;
      angle_packet_type   pending[$];
      int                 errors;
      int                 seen_good;
      int                 seen_digit;
      int                 seen_trailer;

      function new();
         hunting      = 1'b1;
         last_byte    = '0;
         position     = '0;
         digits       = '0;
         digit_fault  = 1'b0;
         errors       = 0;
         seen_good    = 0;
         seen_digit   = 0;
         seen_trailer = 0;
      endfunction

      // Four packed BCD bytes, least significant first, folded into the signed range.
      function logic [27:0] angle_of(logic [31:0] four);
         int sum;
         int weight;
         sum    = 0;
         weight = 1;
         for (int i = 0; i < 4; i++) begin
            sum += (int'(four[8*i+4 +: 4]) * 10 + int'(four[8*i +: 4])) * weight;
            weight *= 100;
         end
         if (sum > int'(bapd_pkg::ANGLE_MAX_POSITIVE)) begin
            sum -= int'(bapd_pkg::ANGLE_BIAS);
         end
         return sum[27:0];
      endfunction

      function void take_byte(logic [7:0] value);
         logic [7:0]       prior;
         angle_packet_type packet;
         prior     = last_byte;
         last_byte = value;
         if (hunting) begin
            if (prior == bapd_pkg::MARK_FIRST && value == bapd_pkg::MARK_SECOND) begin
               hunting     = 1'b0;
               position    = '0;
               digits      = '0;
               digit_fault = 1'b0;
            end
         end else if (position < bapd_pkg::POS_TRAILER_FIRST) begin
            if (value[3:0] > 4'd9 || value[7:4] > 4'd9) begin
               digit_fault = 1'b1;
            end
            digits[8*position +: 8] = value;
            position = position + 4'd1;
         end else if (position == bapd_pkg::POS_TRAILER_FIRST) begin
            position = bapd_pkg::POS_TRAILER_SECOND;
         end else begin
            // A digit fault outranks a bad trailer.
            if (digit_fault) begin
               packet.status = bapd_pkg::STATUS_DIGIT;
            end else if (!(prior > bapd_pkg::TRAILER_MIN &&
                           value == bapd_pkg::TRAILER_END)) begin
               packet.status = bapd_pkg::STATUS_TRAILER;
            end else begin
               packet.status = bapd_pkg::STATUS_GOOD;
            end
            if (packet.status == bapd_pkg::STATUS_GOOD) begin
               packet.first  = angle_of(digits[31:0]);
               packet.second = angle_of(digits[63:32]);
            end else begin
               packet.first  = '0;
               packet.second = '0;
            end
            pending.push_back(packet);
            position    = '0;
            digits      = '0;
            digit_fault = 1'b0;
            hunting     = (packet.status != bapd_pkg::STATUS_GOOD);
         end
      endfunction

      function void check_packet(logic [55:0] data, logic [1:0] user);
         angle_packet_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, tdata %h tuser %0d", $time, data, user);
            return;
         end
         want = pending.pop_front();
         if (data[27:0] !== want.first) begin
            errors++;
            $display("%0t: angle_first expected %0d, got %0d", $time,
                     $signed(want.first), $signed(data[27:0]));
         end
         if (data[55:28] !== want.second) begin
            errors++;
            $display("%0t: angle_second expected %0d, got %0d", $time,
                     $signed(want.second), $signed(data[55:28]));
         end
         if (user !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, user);
         end
         case (want.status)
            bapd_pkg::STATUS_GOOD:  seen_good++;
            bapd_pkg::STATUS_DIGIT: seen_digit++;
            default:                seen_trailer++;
         endcase
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // [27:0] angle_first, [55:28] angle_second
   logic [1:0]  rsp_tuser;         // [1:0] status

   angle_frame_tracker tracker;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent    = 0;
   int cycle_count   = 0;
   int stall_cycles  = 0;
   int hold_left     = 0;
   bit hold_request  = 1'b0;
   bit need_marker   = 1'b0;

   bcd_angle_packet_deframer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: random back-pressure, plus one long hold-off when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Handshakes are sampled at the falling edge, where every signal has settled for the
   // rising edge that follows.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.take_byte(req_tdata);
         end
         if (req_tvalid && !req_tready) begin
            stall_cycles++;
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_packet(rsp_tdata, rsp_tuser);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [63:0] digits, input logic [7:0] first_tail,
                              input logic [7:0] second_tail);
      for (int i = 0; i < 8; i++) begin
         send_byte(digits[8*i +: 8]);
      end
      send_byte(first_tail);
      send_byte(second_tail);
   endtask

   // Mostly ordinary BCD pairs, with the smallest and largest pair mixed in often.
   function automatic logic [63:0] random_digits();
      logic [63:0] digits;
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(7))
            0:       digits[8*i +: 8] = 8'h00;
            1:       digits[8*i +: 8] = 8'h99;
            default: digits[8*i +: 8] = {4'($urandom_range(9)), 4'($urandom_range(9))};
         endcase
      end
      return digits;
   endfunction

   // Well-formed packets dominate; the rest carry bad digits, bad trailers or stray bytes
   // between packets.
   task automatic run_random(input int stop_at);
      int          kind;
      int          spot;
      logic [63:0] digits;
      logic [7:0]  lead;
      logic [7:0]  tail;
      while (bytes_sent < stop_at) begin
         if (need_marker) begin
            if ($urandom_range(3) == 0) begin
               repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
            end
            send_byte(bapd_pkg::MARK_FIRST);
            send_byte(bapd_pkg::MARK_SECOND);
            need_marker = 1'b0;
         end
         kind   = $urandom_range(99);
         digits = random_digits();
         lead   = 8'($urandom_range(255, 10));
         tail   = 8'($urandom_range(255));
         if (tail == bapd_pkg::TRAILER_END) begin
            tail = bapd_pkg::MARK_FIRST;
         end
         if (kind < 75) begin
            send_packet(digits, lead, bapd_pkg::TRAILER_END);
         end else if (kind < 87) begin
            spot = $urandom_range(7);
            if ($urandom_range(1) == 0) begin
               digits[8*spot+4 +: 4] = 4'($urandom_range(15, 10));
            end else begin
               digits[8*spot +: 4] = 4'($urandom_range(15, 10));
            end
            if ($urandom_range(3) == 0) begin
               send_packet(digits, lead, tail);
            end else begin
               send_packet(digits, lead, bapd_pkg::TRAILER_END);
            end
            need_marker = 1'b1;
         end else begin
            case ($urandom_range(2))
               0:       send_packet(digits, 8'($urandom_range(9)), bapd_pkg::TRAILER_END);
               1:       send_packet(digits, lead, tail);
               default: send_packet(digits, 8'($urandom_range(9)), tail);
            endcase
            need_marker = 1'b1;
         end
      end
   endtask

   initial begin
      int base;
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 66;

      // Hunting: stray bytes, a repeated first marker byte, then the marker itself.
      send_byte(8'h0A);
      send_byte(8'hFF);
      send_byte(bapd_pkg::MARK_FIRST);
      send_byte(bapd_pkg::MARK_FIRST);
      send_byte(bapd_pkg::MARK_SECOND);
      // All-zero digits; a good trailer leads straight into the next packet.
      send_packet(64'h0, 8'hFF, bapd_pkg::TRAILER_END);
      // Largest digits everywhere, which fold to minus one; smallest legal trailer lead.
      send_packet(64'h9999999999999999, 8'h0A, bapd_pkg::TRAILER_END);
      // Largest positive angle next to the most negative one.
      send_packet(64'h10000000_09999999, bapd_pkg::MARK_FIRST, bapd_pkg::TRAILER_END);
      // Low nibble above nine; the marker pattern inside the data is not searched again.
      send_packet(64'h00000000_0A0B0000, 8'hFF, bapd_pkg::TRAILER_END);
      send_byte(bapd_pkg::MARK_FIRST);
      send_byte(bapd_pkg::MARK_SECOND);
      // High nibble above nine together with a bad trailer: the digit fault wins.
      send_packet(64'h000000A0_00000000, bapd_pkg::TRAILER_MIN, bapd_pkg::TRAILER_END);
      send_byte(bapd_pkg::MARK_FIRST);
      send_byte(bapd_pkg::MARK_SECOND);
      // Trailer lead of exactly nine is rejected.
      send_packet(64'h12345678_87654321, bapd_pkg::TRAILER_MIN, bapd_pkg::TRAILER_END);
      send_byte(bapd_pkg::MARK_FIRST);
      send_byte(bapd_pkg::MARK_SECOND);
      // Wrong closing byte; that byte then starts the next marker.
      send_packet(64'h00990099_55443322, 8'h0A, bapd_pkg::MARK_FIRST);
      send_byte(bapd_pkg::MARK_SECOND);
      send_packet(64'h99000001_00000099, 8'h80, bapd_pkg::TRAILER_END);
      need_marker = 1'b0;

      base = bytes_sent;
      run_random(base + 240);

      send_idle_pct = 66;
      recv_idle_pct = 35;
      run_random(base + 470);

      // No idling now; a long hold on the result side fills the block and stalls its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      run_random(base + 710);
      req_tvalid <= 1'b0;

      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes; %0d packets decoded: %0d good, %0d digit faults,",
               bytes_sent, tracker.seen_good + tracker.seen_digit + tracker.seen_trailer,
               tracker.seen_good, tracker.seen_digit);
      $display("%0d trailer faults; input held off for %0d cycles by result back-pressure.",
               tracker.seen_trailer, stall_cycles);
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/bapd_pkg.sv
sv/bapd_accum.sv
sv/bcd_angle_packet_deframer_core.sv
verif/tb.sv
